### sv/tw2d_pkg.sv
package tw2d_pkg;

  // Dividend 8*luma*S + 255*P stays below 2^28.
  localparam int unsigned NUM_W = 28;
  // Divisor 510*P stays below 2^25.
  localparam int unsigned DIV_W = 25;
  // Shifted quarter-period index k+1 stays below 2^19.
  localparam int unsigned QUO_W = 19;
  localparam int unsigned REG_W = 16;
  localparam int unsigned BYTE_W = 8;

  // floor(u / 255) == (u * RECIP) >> RECIP_SHIFT for every u below 2^24.
  localparam int unsigned RECIP_W = 25;
  localparam logic [RECIP_W-1:0] RECIP = 25'd16843010;
  localparam int unsigned RECIP_SHIFT = 32;

  localparam int unsigned DEPTH_DIV = 2040;
  localparam int unsigned QUARTER_MUL = 510;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_DEPTH_SCALE = 1'b0;
  localparam logic REG_WAVE_PERIOD = 1'b1;

  localparam logic [REG_W-1:0] DEPTH_SCALE_RST = 16'd4096;
  localparam logic [REG_W-1:0] WAVE_PERIOD_RST = 16'd512;

  typedef struct packed {
    logic              valid;
    logic [NUM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
    logic [BYTE_W-1:0] chroma_a;
    logic [BYTE_W-1:0] chroma_b;
  } cell_t;

endpackage

### sv/tw2d_cell.sv
module tw2d_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [tw2d_pkg::DIV_W-1:0] div_i,
  input  tw2d_pkg::cell_t        cell_i,
  output tw2d_pkg::cell_t        cell_o
);
  import tw2d_pkg::*;

  localparam int unsigned CMP_W = NUM_W + QUO_W;

  logic [CMP_W-1:0] shifted;
  logic             fits;
  cell_t            cell_d;
  cell_t            cell_q;

  // One restoring step: decides quotient bit BIT.
  assign shifted = CMP_W'(div_i) << BIT;
  assign fits    = CMP_W'(cell_i.rem) >= shifted;

  always_comb begin
    cell_d     = cell_i;
    cell_d.quo = {cell_i.quo[QUO_W-2:0], fits};
    if (fits) begin
      cell_d.rem = cell_i.rem - shifted[NUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### sv/tw2d_tail.sv
module tw2d_tail #(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [tw2d_pkg::REG_W-1:0] period_i,
  input  tw2d_pkg::cell_t            cell_i,
  output logic                       valid_o,
  output logic [DEPTH_BITS-1:0]      depth_o
);
  import tw2d_pkg::*;

  localparam int unsigned W_S_W  = NUM_W + 2;
  localparam int unsigned PROD_W = REG_W + NUM_W;
  localparam int unsigned U_W    = DEPTH_BITS + 8;
  localparam int unsigned RP_W   = U_W + RECIP_W;
  localparam logic [PROD_W-1:0] SAT_TH = PROD_W'(DEPTH_DIV) << DEPTH_BITS;

  logic [QUO_W-1:0]        k;
  logic [1:0]              m;
  logic [BYTE_W-1:0]       h;
  logic [NUM_W-1:0]        k510;
  logic signed [W_S_W-1:0] w_s;
  logic [NUM_W-1:0]        w_d;
  logic [NUM_W-1:0]        w_q;
  logic                    va_q;
  logic [PROD_W-1:0]       prod;
  logic [U_W-1:0]          u_q;
  logic                    sat_q;
  logic                    vb_q;
  logic [RP_W-1:0]         rp;

  // The division returned k+1, so the quarter index is one below its low bits.
  assign k    = cell_i.quo;
  assign m    = k[1:0] - 2'd1;
  assign k510 = NUM_W'({k, 9'd0}) - NUM_W'({k, 1'b0});

  always_comb begin
    case (m)
      2'd0:    h = cell_i.chroma_a;
      2'd1:    h = cell_i.chroma_b;
      2'd2:    h = ~cell_i.chroma_a;
      default: h = ~cell_i.chroma_b;
    endcase
  end

  // W = 510*k + 4*h; the 2040*depth product is P*W.
  assign w_s = $signed({2'b00, k510}) + $signed(W_S_W'({h, 2'b00}))
             - $signed(W_S_W'(QUARTER_MUL));
  assign w_d = w_s[W_S_W-1] ? '0 : w_s[NUM_W-1:0];

  assign prod = PROD_W'(period_i) * PROD_W'(w_q);
  assign rp   = RP_W'(u_q) * RP_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= cell_i.valid;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q   <= w_d;
      sat_q <= prod >= SAT_TH;
      u_q   <= prod[U_W+2:3];
    end
  end

  assign valid_o = vb_q;
  assign depth_o = sat_q ? '1 : rp[RECIP_SHIFT +: DEPTH_BITS];

endmodule

### sv/triangle_wave_yuv_to_depth_decoder.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    luma_i, chroma_a_i, chroma_b_i
// out      output     out_valid_o / out_ready_i  depth_o
// cfg      input      psel / penable / pwrite    paddr, pwdata, prdata
//
// One pixel is taken per clock unless the skid entry is full, which drops in_ready_o.
// The input stage loads at the transfer edge, then the row of 19 divider cells,
// one quotient bit each, two final stages and the output register follow.
// Reset clears all valid flags and loads the register defaults.
// A two-entry output buffer absorbs a stall; the pipeline halts only when it is full.
module triangle_wave_yuv_to_depth_decoder #(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            luma_i,
  input  logic [7:0]            chroma_a_i,
  input  logic [7:0]            chroma_b_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DEPTH_BITS-1:0] depth_o
);
  import tw2d_pkg::*;

  logic [REG_W-1:0]      depth_scale_q;
  logic [REG_W-1:0]      wave_period_q;
  logic [REG_W-1:0]      scale_eff;
  logic [REG_W-1:0]      period_eff;
  logic [DIV_W-1:0]      divisor;
  logic [NUM_W-1:0]      num;
  logic                  en;
  cell_t                 front_q;
  cell_t                 chain [QUO_W+1];
  logic                  tail_valid;
  logic [DEPTH_BITS-1:0] tail_depth;
  logic                  out_valid_q;
  logic [DEPTH_BITS-1:0] out_depth_q;
  logic                  skid_valid_q;
  logic [DEPTH_BITS-1:0] skid_depth_q;
  logic                  out_fire;
  logic                  incoming;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_scale_q <= DEPTH_SCALE_RST;
      wave_period_q <= WAVE_PERIOD_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_DEPTH_SCALE: depth_scale_q <= pwdata[REG_W-1:0];
        REG_WAVE_PERIOD: wave_period_q <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEPTH_SCALE: prdata = 32'(depth_scale_q);
      REG_WAVE_PERIOD: prdata = 32'(wave_period_q);
      default:         prdata = '0;
    endcase
  end

  // A zero register acts as one.
  assign scale_eff  = (depth_scale_q == '0) ? REG_W'(1) : depth_scale_q;
  assign period_eff = (wave_period_q == '0) ? REG_W'(1) : wave_period_q;
  assign divisor    = DIV_W'({period_eff, 9'd0}) - DIV_W'({period_eff, 1'b0});

  // Dividend 8*luma*S + 255*P gives k+1, with k the quarter-period index.
  assign num = NUM_W'({luma_i, 3'b000}) * NUM_W'(scale_eff)
             + NUM_W'({period_eff, 8'd0}) - NUM_W'(period_eff);

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else if (en) begin
      front_q.valid    <= in_valid_i;
      front_q.rem      <= num;
      front_q.quo      <= '0;
      front_q.chroma_a <= chroma_a_i;
      front_q.chroma_b <= chroma_b_i;
    end
  end

  assign chain[0] = front_q;

  for (genvar j = 0; j < QUO_W; j++) begin : g_cell
    tw2d_cell #(
      .BIT(QUO_W - 1 - j)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .div_i (divisor),
      .cell_i(chain[j]),
      .cell_o(chain[j+1])
    );
  end

  tw2d_tail #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_tail (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .period_i(period_eff),
    .cell_i  (chain[QUO_W]),
    .valid_o (tail_valid),
    .depth_o (tail_depth)
  );

  // Output register with a skid entry behind it.
  assign out_fire = out_valid_q && out_ready_i;
  assign incoming = en && tail_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (incoming) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_depth_q <= skid_depth_q;
      end
    end else if (incoming) begin
      if (out_valid_q && !out_fire) begin
        skid_depth_q <= tail_depth;
      end else begin
        out_depth_q <= tail_depth;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign depth_o     = out_depth_q;

endmodule
